// ----- hw/rtl/bfa_pkg.sv -----
// Package for the best-fit block allocator: payload structs, command codes.
// No dependencies.
package bfa_pkg;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] request_bytes;
      logic [21:0] release_offset;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [21:0] block_offset;
      logic [22:0] used_bytes;
      logic [22:0] largest_free_bytes;
   } rsp_type;

endpackage

// ----- hw/rtl/bfa_table.sv -----
// Block table memory: per granule a start bit, a free bit and a data length.
// One write port, one read port, registered read data. Depends on nothing.
module bfa_table #(
   parameter int AW = 16,
   parameter int LW = 20
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [LW+1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [LW+1:0] rd_data
);

   logic [LW+1:0] mem [2**AW];
   logic [LW+1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/best_fit_block_allocator_unit.sv -----
// Top level of the best-fit block allocator: sequencer around the block table.
// Depends on bfa_pkg and bfa_table.
//
//  channel | dir | ports
//  req     | in  | req_valid, req_ready, req_data (bfa_pkg::req_type)
//  rsp     | out | rsp_valid, rsp_ready, rsp_data (bfa_pkg::rsp_type)
//  csr     | in  | csr_valid, csr_ready, csr_data (min_alloc_bytes, 23 bits)
//
// One item at a time. After reset a clearing pass writes every table entry;
// no request is taken meanwhile. Every walk of the block chain visits each
// block in S_RD (read issue) and S_WT (read data). A legal allocate walks
// twice (search, then report) with S_SPLIT and S_TAKE between if a block fits;
// a free checks in S_FREE, walks to merge (S_MRD and S_MWT per absorbed
// neighbor, S_TAKE per anchor) and walks to report. A query walks once.
// A waiting result holds the sequencer in DONE until taken.
module best_fit_block_allocator_unit #(
   parameter int ARENA_GRANULES = 65536,
   parameter int GRANULE_BYTES  = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfa_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [22:0]       csr_data
);

   localparam int AW = (ARENA_GRANULES > 1) ? $clog2(ARENA_GRANULES) : 1;
   localparam int LW = AW + 1;     // length up to ARENA_GRANULES - 1, plus headroom
   localparam int GW = AW + 2;     // granule index that can run past the end
   localparam int SH = $clog2(GRANULE_BYTES);
   localparam logic [GW-1:0] GEND = GW'(ARENA_GRANULES);
   localparam logic [63:0] MAXREQ = 64'(ARENA_GRANULES - 1) * 64'(GRANULE_BYTES);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_RD    = 10'b0000000100,  // issue read of block at cur
      S_WT    = 10'b0000001000,  // read data arrives
      S_SPLIT = 10'b0000010000,  // write remainder block
      S_TAKE  = 10'b0000100000,  // write picked block header or merged anchor
      S_FREE  = 10'b0001000000,  // check header of freed block
      S_MRD   = 10'b0010000000,  // merge: read next neighbour
      S_MWT   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   typedef enum logic [2:0] {
      W_SEARCH = 3'b001,
      W_MERGE  = 3'b010,
      W_REPORT = 3'b100
   } walk_type;

   state_type state_ff, state_in;
   walk_type  walk_ff, walk_in;
   logic [GW-1:0] cur_ff, cur_in;      // block being visited
   logic [GW-1:0] anc_ff, anc_in;      // free block absorbing neighbours
   logic [LW-1:0] anc_len_ff, anc_len_in;
   logic [LW-1:0] need_ff, need_in;
   logic [GW-1:0] pick_ff, pick_in;
   logic [LW-1:0] pick_len_ff, pick_len_in;
   logic          found_ff, found_in;
   logic [LW-1:0] best_ff, best_in;
   logic [22:0]   used_ff, used_in;
   logic [22:0]   min_ff;
   logic [21:0]   off_ff, off_in;
   logic          ok_ff, ok_in;
   bfa_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [LW+1:0] wr_data, rd_data;
   logic          rd_start, rd_free;
   logic [LW-1:0] rd_len;
   logic [GW-1:0] nxt;

   bfa_table #(.AW(AW), .LW(LW)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_start = rd_data[LW+1];
   assign rd_free  = rd_data[LW];
   assign rd_len   = rd_data[LW-1:0];
   assign nxt      = cur_ff + GW'(1) + GW'(rd_len);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 23'd64;
      end else if (csr_valid) begin
         min_ff <= csr_data;
      end
   end

   // request decode: legality and granule count
   logic [63:0]   req_w;
   logic          req_legal;
   logic [LW-1:0] req_need;
   logic [GW-1:0] fr_h;
   logic          fr_legal;
   always_comb begin
      req_w     = 64'(req_data.request_bytes);
      req_legal = (req_w >= 64'(min_ff)) && (req_w <= MAXREQ);
      req_need  = LW'((req_w + 64'(GRANULE_BYTES - 1)) >> SH);
      fr_h      = GW'(req_data.release_offset >> SH) - GW'(1);
      fr_legal  = (req_data.release_offset[SH-1:0] == '0) &&
                  (req_data.release_offset >= 22'(GRANULE_BYTES)) && (fr_h < GEND);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      cur_in       = cur_ff;
      anc_in       = anc_ff;
      anc_len_in   = anc_len_ff;
      need_in      = need_ff;
      pick_in      = pick_ff;
      pick_len_in  = pick_len_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      used_in      = used_ff;
      off_in       = off_ff;
      ok_in        = ok_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff[AW-1:0];
      wr_data      = '0;
      rd_addr      = cur_ff[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (cur_ff == '0) wr_data = {1'b1, 1'b1, LW'(ARENA_GRANULES - 1)};
            cur_in = cur_ff + GW'(1);
            if (cur_ff == GEND - GW'(1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ok_in    = 1'b0;
               off_in   = '0;
               cur_in   = '0;
               best_in  = '0;
               found_in = 1'b0;
               need_in  = req_need;
               walk_in  = W_REPORT;
               state_in = S_RD;
               if (req_data.cmd == bfa_pkg::CMD_ALLOC) begin
                  walk_in = W_SEARCH;
                  if (!req_legal) walk_in = W_REPORT;
               end else if (req_data.cmd == bfa_pkg::CMD_FREE) begin
                  state_in = S_IDLE;
                  if (fr_legal) begin
                     cur_in   = fr_h;
                     state_in = S_FREE;
                  end else begin
                     state_in = S_RD;
                  end
                  rd_addr = fr_h[AW-1:0];
               end
            end
         end
         S_FREE: begin
            // rd_data holds header of candidate block
            if (rd_start && !rd_free) begin
               wr_en   = 1'b1;
               wr_data = {1'b1, 1'b1, rd_len};
               used_in = used_ff - (23'(rd_len) << SH);
               walk_in = W_MERGE;
            end
            cur_in   = '0;
            state_in = S_RD;
         end
         S_RD: begin
            rd_addr  = cur_ff[AW-1:0];
            state_in = S_WT;
         end
         S_WT: begin
            state_in = S_RD;
            case (walk_ff)
               W_SEARCH: begin
                  if (rd_free && rd_len >= need_ff &&
                      (!found_ff || rd_len <= pick_len_ff)) begin
                     pick_in     = cur_ff;
                     pick_len_in = rd_len;
                     found_in    = 1'b1;
                  end
                  cur_in = nxt;
                  if (nxt >= GEND) begin
                     if (found_ff || (rd_free && rd_len >= need_ff))
                        state_in = S_SPLIT;
                     else begin
                        walk_in = W_REPORT;
                        cur_in  = '0;
                     end
                  end
               end
               W_MERGE: begin
                  cur_in = nxt;
                  if (rd_free) begin
                     anc_in     = cur_ff;
                     anc_len_in = rd_len;
                     if (nxt < GEND) begin
                        state_in = S_MRD;
                     end
                  end
                  if (nxt >= GEND) begin
                     walk_in = W_REPORT;
                     cur_in  = '0;
                     state_in = S_RD;
                  end
               end
               default: begin
                  if (rd_free && rd_len > best_ff) best_in = rd_len;
                  cur_in = nxt;
                  if (nxt >= GEND) begin
                     rsp_in.ok                 = ok_ff;
                     rsp_in.block_offset       = off_ff;
                     rsp_in.used_bytes         = used_ff;
                     rsp_in.largest_free_bytes = (rd_free && rd_len > best_ff) ?
                        (23'(rd_len) << SH) : (23'(best_ff) << SH);
                     rsp_valid_in = 1'b1;
                     state_in     = S_DONE;
                  end
               end
            endcase
         end
         S_MRD: begin
            rd_addr  = cur_ff[AW-1:0];
            state_in = S_MWT;
         end
         S_MWT: begin
            if (rd_start && rd_free) begin
               // absorb neighbour into anchor
               anc_len_in = anc_len_ff + LW'(1) + rd_len;
               wr_en      = 1'b1;
               wr_addr    = cur_ff[AW-1:0];
               wr_data    = '0;
               cur_in     = nxt;
               state_in   = (nxt < GEND) ? S_MRD : S_TAKE;
            end else begin
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            if (walk_ff == W_MERGE) begin
               // write back merged anchor, continue walk from where merge stopped
               wr_en    = 1'b1;
               wr_addr  = anc_ff[AW-1:0];
               wr_data  = {1'b1, 1'b1, anc_len_ff};
               state_in = S_RD;
               if (cur_ff >= GEND) begin
                  walk_in = W_REPORT;
                  cur_in  = '0;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pick_ff[AW-1:0];
               wr_data  = {1'b1, 1'b0,
                           (pick_len_ff >= need_ff + LW'(2)) ? need_ff : pick_len_ff};
               used_in  = used_ff + (23'((pick_len_ff >= need_ff + LW'(2)) ?
                                         need_ff : pick_len_ff) << SH);
               ok_in    = 1'b1;
               off_in   = 22'(pick_ff + GW'(1)) << SH;
               walk_in  = W_REPORT;
               cur_in   = '0;
               state_in = S_RD;
            end
         end
         S_SPLIT: begin
            if (pick_len_ff >= need_ff + LW'(2)) begin
               wr_en   = 1'b1;
               wr_addr = AW'(pick_ff + GW'(1) + GW'(need_ff));
               wr_data = {1'b1, 1'b1, pick_len_ff - need_ff - LW'(1)};
            end
            state_in = S_TAKE;
         end
         S_DONE: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         walk_ff      <= W_REPORT;
         cur_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         cur_ff       <= cur_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      anc_ff      <= anc_in;
      anc_len_ff  <= anc_len_in;
      need_ff     <= need_in;
      pick_ff     <= pick_in;
      pick_len_ff <= pick_len_in;
      best_ff     <= best_in;
      off_ff      <= off_in;
      ok_ff       <= ok_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ----- hw/rtl/bfa_checker.sv -----
// Port-level checks for the best-fit block allocator, bound to the top level.
// Depends on bfa_pkg.
module bfa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bfa_pkg::rsp_type rsp_data
);

   // a result word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // one item in flight: no input taken while a result waits
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req taken with result pending");

   // a result without ok reports no offset
   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.block_offset == '0)
      else $error("offset without ok");

   // accepting a word starts work, no result in the cycle after
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result without work");

endmodule

bind best_fit_block_allocator_unit bfa_checker u_bfa_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
